>>> hw/rtl/pgg_pkg.sv
package pgg_pkg;

  // Fixed formats
  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = 13;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 17;
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_SCALE = 28;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd256;
  localparam logic [OUT_BITS-1:0] ONE_FX    = 17'd65536;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] radius_value;
    logic [OUT_BITS-1:0] angle_value;
    logic [OUT_BITS-1:0] diamond_value;
    logic [OUT_BITS-1:0] mirror_value;
  } result_word_t;

endpackage

>>> hw/rtl/procedural_gradient_generator_top.sv
// Procedural gradient generator. Every cycle one pixel word may be started
// (busy stays low); its result word appears on result with done high exactly
// 40 cycles later and must be taken in that cycle, since the block cannot
// hold results back. The latency is set by the radius path: sixteen stages
// of a bit-per-stage divider that normalizes the coordinates, a squaring
// stage, and seventeen stages of a bit-per-stage square root; the 28-stage
// angle CORDIC runs in parallel and is delayed to match. Image width and
// height are written at byte addresses 0 and 4; write them only while no
// pixel is in flight. A size of 0 counts as 1.
module procedural_gradient_generator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  pgg_pkg::pixel_word_t      pixel,
  output logic                      done,
  output pgg_pkg::result_word_t     result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DB = pgg_pkg::DIM_BITS;
  localparam int FB = pgg_pkg::FRAC_BITS;
  localparam int OB = pgg_pkg::OUT_BITS;
  localparam int NS = pgg_pkg::CORDIC_STEPS;
  localparam int LAST = 40;

  // Configuration registers
  logic [DB-1:0] image_width;
  logic [DB-1:0] image_height;
  logic [DB-1:0] wsz;
  logic [DB-1:0] hsz;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pgg_pkg::DIM_RESET;
      image_height <= pgg_pkg::DIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == pgg_pkg::REG_IMAGE_WIDTH) image_width <= pwdata[DB-1:0];
      else image_height <= pwdata[DB-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pgg_pkg::REG_IMAGE_WIDTH) prdata[DB-1:0] = image_width;
    else prdata[DB-1:0] = image_height;
  end

  assign wsz = (image_width == '0) ? DB'(1) : image_width;
  assign hsz = (image_height == '0) ? DB'(1) : image_height;

  // Valid bits travel with the words
  logic vld [1:LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= start && !busy;
      for (int k = 2; k <= LAST; k++) vld[k] <= vld[k-1];
    end
  end

  // Stage 1: signed numerators 2*coord+1-size
  logic signed [DB+1:0] nx1, ny1;

  always_ff @(posedge clk) begin
    nx1 <= $signed({2'b0, pixel.pixel_x, 1'b1}) - $signed({2'b0, wsz});
    ny1 <= $signed({2'b0, pixel.pixel_y, 1'b1}) - $signed({2'b0, hsz});
  end

  // Stage 2: magnitudes and sign flags
  logic [DB-1:0] ax2, ay2;
  logic [3:0] flg2;  // {x negative, y negative, x zero, y zero}
  logic signed [DB+1:0] nxn, nyn;

  assign nxn = -nx1;
  assign nyn = -ny1;

  always_ff @(posedge clk) begin
    ax2  <= nx1[DB+1] ? nxn[DB-1:0] : nx1[DB-1:0];
    ay2  <= ny1[DB+1] ? nyn[DB-1:0] : ny1[DB-1:0];
    flg2 <= {nx1[DB+1], ny1[DB+1], nx1 == '0, ny1 == '0};
  end

  // Stage 3: saturation test, cross products, divider seed
  logic [2*DB-1:0] cx3, cy3;
  logic [DB:0] remx [3:19];
  logic [DB:0] remy [3:19];
  logic [FB-1:0] qx [3:19];
  logic [FB-1:0] qy [3:19];
  logic [3:0] flg_d [3:31];
  logic [1:0] sat_d [3:19];

  always_ff @(posedge clk) begin
    cx3 <= ax2 * hsz;
    cy3 <= ay2 * wsz;
    sat_d[3] <= {ax2 >= wsz, ay2 >= hsz};
    flg_d[3] <= flg2;
    remx[3] <= {1'b0, ax2};
    remy[3] <= {1'b0, ay2};
    qx[3] <= '0;
    qy[3] <= '0;
    for (int k = 4; k <= 31; k++) flg_d[k] <= flg_d[k-1];
    for (int k = 4; k <= 19; k++) sat_d[k] <= sat_d[k-1];
  end

  // Stages 4..19: one quotient bit per stage, rounding term size/2 shifted in
  logic [FB-1:0] lowx, lowy;
  assign lowx = FB'(wsz >> 1);
  assign lowy = FB'(hsz >> 1);

  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [DB:0] tx, ty;
    assign tx = {remx[3+j][DB-1:0], lowx[FB-1-j]};
    assign ty = {remy[3+j][DB-1:0], lowy[FB-1-j]};
    always_ff @(posedge clk) begin
      if (tx >= {1'b0, wsz}) begin
        remx[4+j] <= tx - {1'b0, wsz};
        qx[4+j]   <= {qx[3+j][FB-2:0], 1'b1};
      end else begin
        remx[4+j] <= tx;
        qx[4+j]   <= {qx[3+j][FB-2:0], 1'b0};
      end
      if (ty >= {1'b0, hsz}) begin
        remy[4+j] <= ty - {1'b0, hsz};
        qy[4+j]   <= {qy[3+j][FB-2:0], 1'b1};
      end else begin
        remy[4+j] <= ty;
        qy[4+j]   <= {qy[3+j][FB-2:0], 1'b0};
      end
    end
  end

  // Stage 20: saturated magnitudes
  logic [OB-1:0] mx20, my20;
  logic sat20;

  always_ff @(posedge clk) begin
    mx20  <= sat_d[19][1] ? pgg_pkg::ONE_FX : {1'b0, qx[19]};
    my20  <= sat_d[19][0] ? pgg_pkg::ONE_FX : {1'b0, qy[19]};
    sat20 <= |sat_d[19];
  end

  // Stage 21: squares and diamond product
  logic [2*FB-1:0] sqx21, sqy21;
  logic [2*OB-1:0] prod21;
  logic [OB-1:0] mir_d [21:39];
  logic satr_d [21:39];

  always_ff @(posedge clk) begin
    sqx21 <= mx20[FB-1:0] * mx20[FB-1:0];
    sqy21 <= my20[FB-1:0] * my20[FB-1:0];
    prod21 <= (pgg_pkg::ONE_FX - mx20) * (pgg_pkg::ONE_FX - my20);
    satr_d[21] <= sat20;
    for (int k = 22; k <= 39; k++) satr_d[k] <= satr_d[k-1];
    mir_d[21] <= mx20;
    for (int k = 22; k <= 39; k++) mir_d[k] <= mir_d[k-1];
  end

  // Stage 22: sum of squares, diamond rounding
  logic [2*FB+1:0] rv [22:39];
  logic [2*FB+1:0] rr [22:39];
  logic [OB-1:0] dia_d [22:39];
  logic [2*OB-1:0] prnd;

  assign prnd = prod21 + (2*OB)'(1 << (FB-1));

  always_ff @(posedge clk) begin
    rv[22] <= (2*FB+2)'(sqx21) + (2*FB+2)'(sqy21);
    rr[22] <= '0;
    dia_d[22] <= pgg_pkg::ONE_FX - prnd[FB+OB-1:FB];
    for (int k = 23; k <= 39; k++) dia_d[k] <= dia_d[k-1];
  end

  // Stages 23..39: square root, one result bit per stage
  for (genvar t = 0; t <= FB; t++) begin : g_sqrt
    localparam logic [2*FB+1:0] BT = (2*FB+2)'(1) << (2*FB - 2*t);
    logic [2*FB+1:0] cand;
    assign cand = rr[22+t] + BT;
    always_ff @(posedge clk) begin
      if (rv[22+t] >= cand) begin
        rv[23+t] <= rv[22+t] - cand;
        rr[23+t] <= (rr[22+t] >> 1) + BT;
      end else begin
        rv[23+t] <= rv[22+t];
        rr[23+t] <= rr[22+t] >> 1;
      end
    end
  end

  // Stages 4..31: angle CORDIC on the exact cross products
  localparam int CW = 2*DB + pgg_pkg::CORDIC_SCALE + 3;
  localparam int ZW = 34;
  logic signed [CW-1:0] cxs [3:31];
  logic signed [CW-1:0] cys [3:31];
  logic signed [ZW-1:0] cz  [3:31];

  assign cxs[3] = $signed({3'b0, cx3, {pgg_pkg::CORDIC_SCALE{1'b0}}});
  assign cys[3] = $signed({3'b0, cy3, {pgg_pkg::CORDIC_SCALE{1'b0}}});
  assign cz[3]  = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = cys[3+i] >>> i;
    assign dy = cxs[3+i] >>> i;
    assign at = $signed({2'b0, pgg_pkg::ATAN_TURN[i]});
    always_ff @(posedge clk) begin
      if (cys[3+i] > 0) begin
        cxs[4+i] <= cxs[3+i] + dx;
        cys[4+i] <= cys[3+i] - dy;
        cz[4+i]  <= cz[3+i] + at;
      end else if (cys[3+i] < 0) begin
        cxs[4+i] <= cxs[3+i] - dx;
        cys[4+i] <= cys[3+i] + dy;
        cz[4+i]  <= cz[3+i] - at;
      end else begin
        cxs[4+i] <= cxs[3+i];
        cys[4+i] <= cys[3+i];
        cz[4+i]  <= cz[3+i];
      end
    end
  end

  // Stage 32: clamp to a quarter turn and fold into the quadrant
  localparam logic signed [ZW-1:0] QTR  = ZW'(64'sd1 << 30);
  localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 << 31);
  logic signed [ZW-1:0] a1, a2, turns32;

  always_comb begin
    if (cz[31] < 0) a1 = '0;
    else if (cz[31] > QTR) a1 = QTR;
    else a1 = cz[31];
    a2 = flg_d[31][3] ? HALF - a1 : a1;
  end

  always_ff @(posedge clk) begin
    if (flg_d[31][1]) begin
      if (flg_d[31][0]) turns32 <= '0;
      else if (flg_d[31][2]) turns32 <= -QTR;
      else turns32 <= QTR;
    end else begin
      turns32 <= flg_d[31][2] ? -a2 : a2;
    end
  end

  // Stage 33: offset by half a turn and round to output precision
  logic [ZW-1:0] asum;
  logic [ZW-FB-1:0] ashort;
  logic [OB-1:0] ang_d [33:39];

  assign asum   = $unsigned(turns32 + HALF + ZW'(64'sd1 << (31 - FB)));
  assign ashort = asum[ZW-1:32-FB];

  always_ff @(posedge clk) begin
    ang_d[33] <= (ashort > (ZW-FB)'(pgg_pkg::ONE_FX)) ? pgg_pkg::ONE_FX : ashort[OB-1:0];
    for (int k = 34; k <= 39; k++) ang_d[k] <= ang_d[k-1];
  end

  // Stage 40: output word
  assign done = vld[LAST];

  always_ff @(posedge clk) begin
    if (satr_d[39] || rr[39] > (2*FB+2)'(pgg_pkg::ONE_FX))
      result.radius_value <= pgg_pkg::ONE_FX;
    else
      result.radius_value <= rr[39][OB-1:0];
    result.angle_value   <= ang_d[39];
    result.diamond_value <= dia_d[39];
    result.mirror_value  <= mir_d[39];
  end

endmodule

>>> test/pgg_result_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the gradient generator,
// predicts every result word from its own copy of the image size and
// compares in arrival order.
module pgg_result_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  pgg_pkg::pixel_word_t  pixel,
  input  logic                  done,
  input  pgg_pkg::result_word_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    pending,
  output int                    errors
);

  localparam longint unsigned UNIT = 64'd1 << pgg_pkg::FRAC_BITS;

  logic [pgg_pkg::DIM_BITS-1:0] width_q;
  logic [pgg_pkg::DIM_BITS-1:0] height_q;
  pgg_pkg::result_word_t        gradient_q[$];

  assign pending = gradient_q.size();

  // Rounded magnitude of n / size with FRAC_BITS fraction bits
  function automatic longint unsigned ndc_mag(longint n, longint unsigned sz);
    longint unsigned m;
    m = (n < 0) ? -n : n;
    return ((m << pgg_pkg::FRAC_BITS) + sz / 2) / sz;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // First-quadrant angle of (ax, ay) in 2^-32 turn, clamped to a quarter turn
  function automatic longint quarter_turn(longint ax, longint ay);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = ax <<< pgg_pkg::CORDIC_SCALE;
    y = ay <<< pgg_pkg::CORDIC_SCALE;
    z = 0;
    for (int i = 0; i < pgg_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(pgg_pkg::ATAN_TURN[i]);
      end else if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(pgg_pkg::ATAN_TURN[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    return z;
  endfunction

  function automatic pgg_pkg::result_word_t gradients(pgg_pkg::pixel_word_t p,
                                                      logic [pgg_pkg::DIM_BITS-1:0] wd,
                                                      logic [pgg_pkg::DIM_BITS-1:0] ht);
    pgg_pkg::result_word_t r;
    longint          w;
    longint          h;
    longint          nx;
    longint          ny;
    longint          turns;
    longint          a1;
    longint unsigned mx;
    longint unsigned my;
    longint unsigned rad;
    longint unsigned ang;
    longint unsigned cx;
    longint unsigned cy;
    longint unsigned prod;
    longint unsigned dia;
    w  = (wd == 0) ? 1 : longint'(wd);
    h  = (ht == 0) ? 1 : longint'(ht);
    nx = 2 * longint'(p.pixel_x) + 1 - w;
    ny = 2 * longint'(p.pixel_y) + 1 - h;
    mx = ndc_mag(nx, w);
    my = ndc_mag(ny, h);
    // radial: saturate once either axis leaves the unit square
    if (mx >= UNIT || my >= UNIT) rad = UNIT;
    else begin
      rad = int_sqrt(mx * mx + my * my);
      if (rad > UNIT) rad = UNIT;
    end
    // angular: centre column is handled exactly
    if (nx == 0) begin
      turns = (ny > 0) ? (64'sd1 <<< 30) : ((ny < 0) ? -(64'sd1 <<< 30) : 0);
    end else begin
      a1 = quarter_turn(((nx < 0) ? -nx : nx) * h, ((ny < 0) ? -ny : ny) * w);
      if (nx < 0) a1 = (64'sd1 <<< 31) - a1;
      turns = (ny < 0) ? -a1 : a1;
    end
    ang = ($unsigned(turns + (64'sd1 <<< 31)) + (64'd1 << (31 - pgg_pkg::FRAC_BITS)))
          >> (32 - pgg_pkg::FRAC_BITS);
    if (ang > UNIT) ang = UNIT;
    // diamond and mirror on saturated magnitudes
    cx   = (mx > UNIT) ? UNIT : mx;
    cy   = (my > UNIT) ? UNIT : my;
    prod = ((UNIT - cx) * (UNIT - cy) + (UNIT >> 1)) >> pgg_pkg::FRAC_BITS;
    dia  = UNIT - prod;
    r.radius_value  = rad[pgg_pkg::OUT_BITS-1:0];
    r.angle_value   = ang[pgg_pkg::OUT_BITS-1:0];
    r.diamond_value = dia[pgg_pkg::OUT_BITS-1:0];
    r.mirror_value  = cx[pgg_pkg::OUT_BITS-1:0];
    return r;
  endfunction

  // Track size registers, queue predictions, compare result words
  always @(posedge clk) begin
    pgg_pkg::result_word_t exp_w;
    if (rst) begin
      width_q  <= pgg_pkg::DIM_RESET;
      height_q <= pgg_pkg::DIM_RESET;
      gradient_q.delete();
      errors   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == pgg_pkg::REG_IMAGE_HEIGHT) height_q <= pwdata[pgg_pkg::DIM_BITS-1:0];
        else width_q <= pwdata[pgg_pkg::DIM_BITS-1:0];
      end
      if (start && !busy) gradient_q.push_back(gradients(pixel, width_q, height_q));
      if (done) begin
        if (gradient_q.size() == 0) begin
          $error("result word with no pixel pending");
          errors <= errors + 1;
        end else begin
          exp_w = gradient_q.pop_front();
          if (result.radius_value !== exp_w.radius_value)
            $error("radius_value expected %0d got %0d", exp_w.radius_value,
                   result.radius_value);
          if (result.angle_value !== exp_w.angle_value)
            $error("angle_value expected %0d got %0d", exp_w.angle_value,
                   result.angle_value);
          if (result.diamond_value !== exp_w.diamond_value)
            $error("diamond_value expected %0d got %0d", exp_w.diamond_value,
                   result.diamond_value);
          if (result.mirror_value !== exp_w.mirror_value)
            $error("mirror_value expected %0d got %0d", exp_w.mirror_value,
                   result.mirror_value);
          if (result !== exp_w) errors <= errors + 1;
        end
      end
    end
  end

endmodule

>>> test/procedural_gradient_generator_top_tb.sv
`timescale 1ns / 100ps

module procedural_gradient_generator_top_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int CB = pgg_pkg::COORD_BITS;
  localparam int DW = pgg_pkg::DIM_BITS;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  pgg_pkg::pixel_word_t  pixel;
  logic                  done;
  pgg_pkg::result_word_t result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    pending;
  int                    errors;
  int                    stall_cnt;
  int                    pixels_sent;

  logic [DW-1:0] phase_w [PHASES] = '{13'd256, 13'd255, 13'd1, 13'd0, 13'd4096,
                                      13'd8191, 13'd640, 13'd3, 13'd0, 13'd0};
  logic [DW-1:0] phase_h [PHASES] = '{13'd256, 13'd255, 13'd1, 13'd0, 13'd4096,
                                      13'd8191, 13'd480, 13'd7, 13'd0, 13'd0};

  procedural_gradient_generator_top dut (
    .clk, .rst, .start, .busy, .pixel, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pgg_result_checker result_chk (
    .clk, .rst, .start, .busy, .pixel, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .errors
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("** procedural_gradient_generator_top: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(logic idx, logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one pixel word and hold until it is taken, then maybe pause
  task automatic send_pixel(logic [CB-1:0] x, logic [CB-1:0] y, bit may_idle);
    start <= 1'b1;
    pixel <= '{pixel_x: x, pixel_y: y};
    do @(posedge clk); while (busy);
    pixels_sent++;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Hold off until every predicted word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] pick_coord(logic [DW-1:0] sz);
    int lim;
    lim = (sz == 0) ? 1 : ((sz > 4096) ? 4096 : int'(sz));
    if ($urandom_range(0, 6) == 0) return CB'($urandom_range(0, 4095));
    return CB'($urandom_range(0, lim - 1));
  endfunction

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    pixel       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pixels_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes: corners, coordinate extremes
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd255, 12'd255, 1'b0);
    send_pixel(12'd0, 12'd255, 1'b1);
    send_pixel(12'd255, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    send_pixel(12'd4095, 12'd0, 1'b1);
    send_pixel(12'd0, 12'd4095, 1'b0);
    send_pixel(12'd2730, 12'd1365, 1'b0);
    send_pixel(12'd1365, 12'd2730, 1'b0);
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      logic [DW-1:0] w;
      logic [DW-1:0] h;
      w = phase_w[ph];
      h = phase_h[ph];
      if (ph >= 8) begin
        w = DW'($urandom_range(1, 4096));
        h = DW'($urandom_range(1, 4096));
      end
      reg_write(pgg_pkg::REG_IMAGE_WIDTH, w);
      reg_write(pgg_pkg::REG_IMAGE_HEIGHT, h);
      // Odd size: exact centre and centre column/row
      if (ph == 1) begin
        send_pixel(12'd127, 12'd127, 1'b0);
        send_pixel(12'd127, 12'd0, 1'b0);
        send_pixel(12'd127, 12'd254, 1'b0);
        send_pixel(12'd0, 12'd127, 1'b0);
        send_pixel(12'd254, 12'd127, 1'b0);
        send_pixel(12'd127, 12'd4095, 1'b0);
      end
      for (int i = 0; i < 44; i++)
        send_pixel(pick_coord(w), pick_coord(h), ph < 8);
      drain();
    end

    $display("Sent %0d pixel words across %0d image-size settings, zero and 13-bit max",
             pixels_sent, PHASES);
    $display("included, with random start gaps and out-of-range coordinates.");
    if (errors == 0) $display("** procedural_gradient_generator_top: PASSED **");
    else $display("** procedural_gradient_generator_top: FAILED **");
    $finish;
  end

endmodule
